### sv/assert_macros.svh
// Assertion macros shared by the nearest palette color match RTL.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NPCM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("npcm assertion failed");
`define NPCM_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("npcm forbidden condition seen");
`else
`define NPCM_ASSERT(label, clk, rst, prop)
`define NPCM_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### sv/npcm_pkg.sv
// Package for the nearest palette color match block: sizes, codes, types.
// Used by npcm_palette, npcm_dist and nearest_palette_color_match.
package npcm_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int CH_W            = 5;
   localparam int COLOR_W         = 3 * CH_W;
   localparam int SQ_W            = 2 * CH_W;
   localparam int DIST_W          = SQ_W + 2;
   localparam int IN_IDX_W        = 8;
   localparam int RGB565_W        = 16;

   localparam logic [DIST_W-1:0] BEST_INIT = '1;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [COLOR_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic               valid;
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] pix;
      logic [COLOR_W-1:0] entry;
   } dist_req_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] sq_dist;
   } dist_rsp_type;

   // RGB565 to RGB555: keep red and blue, drop the low green bit.
   function automatic logic [COLOR_W-1:0] reduce565(input logic [RGB565_W-1:0] c);
      return {c[15:11], c[10:6], c[4:0]};
   endfunction

endpackage

### sv/npcm_palette.sv
// Palette store: one write port, one registered read port, per-entry valid bits.
// Depends on npcm_pkg; entries not written since reset read as black.
module npcm_palette
   import npcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  wr_req_type         wr,
   input  rd_req_type         rd,
   output logic [COLOR_W-1:0] rd_color
);

   logic [COLOR_W-1:0]         mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [PALETTE_ENTRIES-1:0] valid_in;
   logic [COLOR_W-1:0]         rd_data_ff;
   logic                       rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff  <= mem_ff[rd.addr];
         rd_valid_ff <= valid_ff[rd.addr];
      end
   end

   assign rd_color = rd_valid_ff ? rd_data_ff : '0;

endmodule

### sv/npcm_dist.sv
// Shared distance unit: squared RGB555 distance of pixel and palette entry, registered.
// Depends on npcm_pkg.
module npcm_dist
   import npcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dist_req_type req,
   output dist_rsp_type rsp
);

   logic [CH_W-1:0]   ad_r;
   logic [CH_W-1:0]   ad_g;
   logic [CH_W-1:0]   ad_b;
   logic [DIST_W-1:0] dist_in;
   logic              valid_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DIST_W-1:0] dist_ff;

   function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      ad_r    = absdiff(req.pix[3*CH_W-1:2*CH_W], req.entry[3*CH_W-1:2*CH_W]);
      ad_g    = absdiff(req.pix[2*CH_W-1:CH_W], req.entry[2*CH_W-1:CH_W]);
      ad_b    = absdiff(req.pix[CH_W-1:0], req.entry[CH_W-1:0]);
      dist_in = DIST_W'(SQ_W'(ad_r * ad_r)) + DIST_W'(SQ_W'(ad_g * ad_g))
              + DIST_W'(SQ_W'(ad_b * ad_b));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= req.idx;
      dist_ff <= dist_in;
   end

   assign rsp = '{valid: valid_ff, idx: idx_ff, sq_dist: dist_ff};

endmodule

### sv/nearest_palette_color_match.sv
// Top level of the nearest palette color match block: sequencer and best-match tracking.
// Depends on npcm_pkg, npcm_palette, npcm_dist and assert_macros.svh.
//
// Usage: drive req_* and raise start; a beat is taken on a clock edge where start
// is high and busy is low. A load beat (req_op = 0) writes one palette entry as
// RGB555 in that edge; busy stays low and no result follows. Loads at or above
// PALETTE_ENTRIES are dropped.
// A query beat (req_op = 1) raises busy while it scans every entry, one entry per
// cycle through the single palette read port and the one distance unit, and then
// while it drains the read, distance and compare stages. The result then sits on
// rsp_palette_index and rsp_last_index for exactly one cycle with rsp_strobe high,
// starting in the first cycle in which busy is low again; it is taken at the edge
// that ends that cycle. Ties go to the lowest entry. No new beat is taken while a
// query is in flight; a new beat may be taken in the strobe cycle.
// The receiver cannot stall: each result beat is taken in its strobe cycle.
// Synchronous reset returns the sequencer to idle, drops any pending result and
// marks every palette entry black, with no clearing pass.
`include "assert_macros.svh"

module nearest_palette_color_match
   import npcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [IN_IDX_W-1:0] req_entry_index,
   input  logic [RGB565_W-1:0] req_color,
   input  logic                req_last_pixel,
   output logic                rsp_strobe,
   output logic [IN_IDX_W-1:0] rsp_palette_index,
   output logic                rsp_last_index
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;
   logic               last_ff, last_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [IN_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               issue;
   wr_req_type         wr;
   rd_req_type         rd;
   logic [COLOR_W-1:0] entry_color;
   dist_req_type       dreq;
   dist_rsp_type       drsp;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign issue  = (state_ff == ST_SCAN);

   always_comb begin
      wr.en   = accept && (op_type'(req_op) == OP_LOAD)
             && ({1'b0, req_entry_index} < (IN_IDX_W + 1)'(PALETTE_ENTRIES));
      wr.addr = IDX_W'(req_entry_index);
      wr.data = reduce565(req_color);
      rd.en   = issue;
      rd.addr = cnt_ff;
   end

   npcm_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .rd_color (entry_color)
   );

   assign dreq = '{valid: s1_valid_ff, idx: s1_idx_ff, pix: pix_ff, entry: entry_color};

   npcm_dist u_dist (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pix_in        = pix_ff;
      last_in       = last_ff;
      s1_valid_in   = issue;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;

      if (drsp.valid && (drsp.sq_dist < best_dist_ff)) begin
         best_dist_in = drsp.sq_dist;
         best_idx_in  = drsp.idx;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op_type'(req_op) == OP_QUERY)) begin
               state_in     = ST_SCAN;
               cnt_in       = '0;
               pix_in       = reduce565(req_color);
               last_in      = req_last_pixel;
               best_dist_in = BEST_INIT;
               best_idx_in  = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(PALETTE_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !drsp.valid) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_index_in  = IN_IDX_W'(best_idx_ff);
               rsp_last_in   = last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      pix_ff       <= pix_in;
      last_ff      <= last_in;
      s1_idx_ff    <= cnt_ff;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_last_index    = rsp_last_ff;

   `NPCM_ASSERT(a_query_sets_busy, clock, reset, (accept && req_op) |=> busy)
   `NPCM_ASSERT(a_strobe_when_idle, clock, reset, rsp_strobe |-> !busy)
   `NPCM_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `NPCM_ASSERT(a_stage_in_search, clock, reset, drsp.valid |-> busy)
   `NPCM_ASSERT_NEVER(a_no_write_in_search, clock, reset, wr.en && busy)

endmodule
